// ----- design/nlr_pkg.sv -----
// ----------------------------------------------------------------------------
// nlr_pkg: shared types and constants for the numeric literal recognizer
// Phase and status codes, character codes, class flags, field widths.
// ----------------------------------------------------------------------------
package nlr_pkg;

    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 3;
    localparam int TOKEN_W  = 7;
    localparam int LINE_W   = 32;

    // output tdata: status, token_length, line_number, zero padded to bytes
    localparam int OUT_FIELDS_W = STATUS_W + TOKEN_W + LINE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_EXP_LO  = 8'h65;
    localparam logic [CHAR_W-1:0] CH_EXP_UP  = 8'h45;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;

    typedef enum logic [2:0] {
        PH_START     = 3'd0,
        PH_SIGN      = 3'd1,
        PH_INT       = 3'd2,
        PH_DOT       = 3'd3,
        PH_FRAC      = 3'd4,
        PH_EXPMARK   = 3'd5,
        PH_EXPSIGN   = 3'd6,
        PH_EXPDIGITS = 3'd7
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_SKIP  = 3'd0,
        ST_TAKEN = 3'd1,
        ST_DONE  = 3'd2,
        ST_NONUM = 3'd3,
        ST_BAD   = 3'd4,
        ST_EARLY = 3'd5,
        ST_LONE  = 3'd6
    } t_status;

    typedef struct packed {
        logic digit;
        logic sign;
        logic expo;
        logic dot;
        logic space;
        logic newline;
    } t_char_class;

endpackage

// ----- design/numeric_literal_recognizer.sv -----
// ----------------------------------------------------------------------------
// numeric_literal_recognizer: streaming decimal number literal scanner
// Path: each input transaction passes the input register, then the result register, to m_axis.
// Throughput: one transaction per cycle while m_axis accepts results; the scan state is read
//   and updated in the single step between the input register and the result register.
// Reset: synchronous active-low; scan returns to start, counts cleared,
//   both pipeline registers emptied.
// ----------------------------------------------------------------------------
module numeric_literal_recognizer #(
    parameter int MAX_TOKEN_LENGTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [nlr_pkg::CHAR_W-1:0]         s_axis_tdata,  // [7:0] character
    input  logic                               s_axis_tuser,  // [0] end_of_stream
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [nlr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // [2:0] status,
                                                              // [9:3] token_length,
                                                              // [41:10] line_number,
                                                              // [47:42] zero
);

    // ---------------- input register ----------------
    logic                          r_in_valid;
    logic [nlr_pkg::CHAR_W-1:0]    r_in_char;
    logic                          r_in_eos;

    // ---------------- scan state ----------------
    nlr_pkg::t_phase               r_phase;
    nlr_pkg::t_phase               n_phase;
    logic [nlr_pkg::TOKEN_W-1:0]   r_token_cnt;
    logic [nlr_pkg::TOKEN_W-1:0]   n_token_cnt;
    logic [nlr_pkg::LINE_W-1:0]    r_line_cnt;
    logic [nlr_pkg::LINE_W-1:0]    n_line_cnt;

    // ---------------- result register ----------------
    logic                          r_out_valid;
    nlr_pkg::t_status              r_out_status;
    logic [nlr_pkg::TOKEN_W-1:0]   r_out_len;
    logic [nlr_pkg::LINE_W-1:0]    r_out_line;

    nlr_pkg::t_char_class          w_class;
    nlr_pkg::t_status              w_status;
    logic [nlr_pkg::TOKEN_W-1:0]   w_token_len;
    logic                          w_adv;   // item moves input reg -> result reg

    // Stage advance: result slot free or being drained this cycle.
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    nlr_char_class u_class (
        .i_char  (r_in_char),
        .o_class (w_class)
    );

    nlr_scan_step #(
        .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH)
    ) u_step (
        .i_phase     (r_phase),
        .i_token_cnt (r_token_cnt),
        .i_class     (w_class),
        .i_eos       (r_in_eos),
        .o_phase     (n_phase),
        .o_token_cnt (n_token_cnt),
        .o_status    (w_status),
        .o_token_len (w_token_len)
    );

    // Newline counts regardless of what it does to the token, except on the end_of_stream item; saturating.
    always_comb begin
        n_line_cnt = r_line_cnt;
        if (!r_in_eos && w_class.newline && (r_line_cnt != {nlr_pkg::LINE_W{1'b1}})) begin
            n_line_cnt = r_line_cnt + 1'b1;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
            r_in_eos  <= s_axis_tuser;
        end
    end

    // Scan state, updated once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= nlr_pkg::PH_START;
            r_token_cnt <= '0;
            r_line_cnt  <= '0;
        end else if (w_adv) begin
            r_phase     <= n_phase;
            r_token_cnt <= n_token_cnt;
            r_line_cnt  <= n_line_cnt;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_status <= w_status;
            r_out_len    <= w_token_len;
            r_out_line   <= n_line_cnt;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(nlr_pkg::OUT_TDATA_W - nlr_pkg::OUT_FIELDS_W){1'b0}},
                            r_out_line, r_out_len, r_out_status};

    // ---------------- assertions ----------------
    // At scan start no token is in progress.
    a_start_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == nlr_pkg::PH_START) |-> (r_token_cnt == '0))
        else $error("token count nonzero at scan start");

    // Skipped or no-number results carry zero length.
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_out_status == nlr_pkg::ST_SKIP) ||
                         (r_out_status == nlr_pkg::ST_NONUM))) |-> (r_out_len == '0))
        else $error("nonzero length on skip/no-number result");

    // Reported length never passes the limit.
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_len <= nlr_pkg::TOKEN_W'(MAX_TOKEN_LENGTH)))
        else $error("token length above limit");

    // Line count moves by at most one per item and never back.
    a_line_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> ((r_line_cnt == $past(r_line_cnt)) ||
                   (r_line_cnt == $past(r_line_cnt) + 32'd1)))
        else $error("line count stepped wrongly");

endmodule

// ----- design/nlr_char_class.sv -----
// ----------------------------------------------------------------------------
// nlr_char_class: byte classifier
// Decodes one byte into the character classes the scanner acts on.
// ----------------------------------------------------------------------------
module nlr_char_class (
    input  logic [nlr_pkg::CHAR_W-1:0] i_char,
    output nlr_pkg::t_char_class       o_class
);

    always_comb begin
        o_class.digit   = (i_char >= nlr_pkg::CH_ZERO) && (i_char <= nlr_pkg::CH_NINE);
        o_class.sign    = (i_char == nlr_pkg::CH_PLUS) || (i_char == nlr_pkg::CH_MINUS);
        o_class.expo    = (i_char == nlr_pkg::CH_EXP_LO) || (i_char == nlr_pkg::CH_EXP_UP);
        o_class.dot     = (i_char == nlr_pkg::CH_DOT);
        // space plus tab..carriage return
        o_class.space   = (i_char == nlr_pkg::CH_SPACE) ||
                          ((i_char >= nlr_pkg::CH_TAB) && (i_char <= nlr_pkg::CH_CR));
        o_class.newline = (i_char == nlr_pkg::CH_NEWLINE);
    end

endmodule

// ----- design/nlr_scan_step.sv -----
// ----------------------------------------------------------------------------
// nlr_scan_step: scanner transition logic
// Next phase, next token count and per-item status from the current state.
// ----------------------------------------------------------------------------
module nlr_scan_step #(
    parameter int MAX_TOKEN_LENGTH = 64
) (
    input  nlr_pkg::t_phase                i_phase,
    input  logic [nlr_pkg::TOKEN_W-1:0]    i_token_cnt,
    input  nlr_pkg::t_char_class           i_class,
    input  logic                           i_eos,
    output nlr_pkg::t_phase                o_phase,
    output logic [nlr_pkg::TOKEN_W-1:0]    o_token_cnt,
    output nlr_pkg::t_status               o_status,
    output logic [nlr_pkg::TOKEN_W-1:0]    o_token_len
);

    localparam logic [nlr_pkg::TOKEN_W-1:0] MaxLen = nlr_pkg::TOKEN_W'(MAX_TOKEN_LENGTH);

    logic                          take;
    nlr_pkg::t_phase               goto_phase;
    nlr_pkg::t_status              end_status;
    logic [nlr_pkg::TOKEN_W-1:0]   cnt_inc;

    always_comb begin
        take       = 1'b0;
        goto_phase = i_phase;
        end_status = nlr_pkg::ST_NONUM;
        unique case (i_phase)
            nlr_pkg::PH_START: begin
                if (i_eos) end_status = nlr_pkg::ST_NONUM;
                else if (i_class.space) end_status = nlr_pkg::ST_SKIP;
                else if (i_class.sign) begin
                    take = 1'b1; goto_phase = nlr_pkg::PH_SIGN;
                end else if (i_class.digit) begin
                    take = 1'b1; goto_phase = nlr_pkg::PH_INT;
                end else if (i_class.dot) begin
                    take = 1'b1; goto_phase = nlr_pkg::PH_DOT;
                end else end_status = nlr_pkg::ST_NONUM;
            end
            nlr_pkg::PH_SIGN: begin
                end_status = nlr_pkg::ST_LONE;
                if (!i_eos) begin
                    if (i_class.digit) begin
                        take = 1'b1; goto_phase = nlr_pkg::PH_INT;
                    end else if (i_class.dot) begin
                        take = 1'b1; goto_phase = nlr_pkg::PH_DOT;
                    end else if (i_class.expo) begin
                        // sign straight into exponent is accepted
                        take = 1'b1; goto_phase = nlr_pkg::PH_EXPMARK;
                    end
                end
            end
            nlr_pkg::PH_INT: begin
                end_status = nlr_pkg::ST_DONE;
                if (!i_eos) begin
                    if (i_class.digit) take = 1'b1;
                    else if (i_class.dot) begin
                        take = 1'b1; goto_phase = nlr_pkg::PH_DOT;
                    end else if (i_class.expo) begin
                        take = 1'b1; goto_phase = nlr_pkg::PH_EXPMARK;
                    end
                end
            end
            nlr_pkg::PH_DOT: begin
                end_status = i_eos ? nlr_pkg::ST_EARLY : nlr_pkg::ST_BAD;
                if (!i_eos && i_class.digit) begin
                    take = 1'b1; goto_phase = nlr_pkg::PH_FRAC;
                end
            end
            nlr_pkg::PH_FRAC: begin
                end_status = nlr_pkg::ST_DONE;
                if (!i_eos) begin
                    if (i_class.digit) take = 1'b1;
                    else if (i_class.expo) begin
                        take = 1'b1; goto_phase = nlr_pkg::PH_EXPMARK;
                    end
                end
            end
            nlr_pkg::PH_EXPMARK: begin
                end_status = i_eos ? nlr_pkg::ST_EARLY : nlr_pkg::ST_BAD;
                if (!i_eos) begin
                    if (i_class.sign) begin
                        take = 1'b1; goto_phase = nlr_pkg::PH_EXPSIGN;
                    end else if (i_class.digit) begin
                        take = 1'b1; goto_phase = nlr_pkg::PH_EXPDIGITS;
                    end
                end
            end
            nlr_pkg::PH_EXPSIGN: begin
                end_status = i_eos ? nlr_pkg::ST_EARLY : nlr_pkg::ST_BAD;
                if (!i_eos && i_class.digit) begin
                    take = 1'b1; goto_phase = nlr_pkg::PH_EXPDIGITS;
                end
            end
            nlr_pkg::PH_EXPDIGITS: begin
                end_status = nlr_pkg::ST_DONE;
                if (!i_eos && i_class.digit) take = 1'b1;
            end
            default: begin
                end_status = nlr_pkg::ST_NONUM;
            end
        endcase
    end

    // token count and reported length saturate at the limit; the token itself is not cut off
    assign cnt_inc = (i_token_cnt < MaxLen) ? i_token_cnt + 1'b1 : i_token_cnt;

    always_comb begin
        if (take) begin
            o_status    = nlr_pkg::ST_TAKEN;
            o_phase     = goto_phase;
            o_token_cnt = cnt_inc;
            o_token_len = cnt_inc;
        end else begin
            o_status = end_status;
            if ((end_status == nlr_pkg::ST_SKIP) || (end_status == nlr_pkg::ST_NONUM)) begin
                o_token_len = '0;
            end else begin
                o_token_len = i_token_cnt;
            end
            if (end_status == nlr_pkg::ST_SKIP) begin
                o_phase     = i_phase;
                o_token_cnt = i_token_cnt;
            end else begin
                o_phase     = nlr_pkg::PH_START;
                o_token_cnt = '0;
            end
        end
    end

endmodule
